// File: design/kclc_pkg.sv
`timescale 1ns / 1ps
// Package for the keypad code lock controller: word types, register map,
// key codes, mode and event codes. No dependencies.
package kclc_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_SECRET_CODE   = 3'd0;
  localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd1;
  localparam logic [2:0] REG_RELOCK_TICKS  = 3'd2;
  localparam logic [2:0] REG_LOCKED_DUTY   = 3'd3;
  localparam logic [2:0] REG_UNLOCKED_DUTY = 3'd4;

  localparam logic [15:0] SECRET_CODE_RST   = 16'd0;
  localparam logic [3:0]  ATTEMPT_LIMIT_RST = 4'd3;
  localparam logic [15:0] RELOCK_TICKS_RST  = 16'd10000;
  localparam logic [12:0] LOCKED_DUTY_RST   = 13'd600;
  localparam logic [12:0] UNLOCKED_DUTY_RST = 13'd250;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] KEY_CLEAR = 8'h2A;
  localparam logic [7:0] KEY_ENTER = 8'h44;

  localparam logic [1:0] LM_READY  = 2'd0;
  localparam logic [1:0] LM_OPEN   = 2'd1;
  localparam logic [1:0] LM_ALARM  = 2'd2;
  localparam logic [1:0] LM_WRONG  = 2'd3;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_GRANTED  = 3'd1;
  localparam logic [2:0] EV_DENIED   = 3'd2;
  localparam logic [2:0] EV_ALARM    = 3'd3;
  localparam logic [2:0] EV_RELOCKED = 3'd4;

  localparam logic [3:0] FAIL_MAX = 4'hF;

  typedef enum logic [3:0] {
    MODE_READY = 4'b0001,
    MODE_OPEN  = 4'b0010,
    MODE_ALARM = 4'b0100,
    MODE_WRONG = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic [12:0] servo_duty;
    logic        led_on;
    logic        buzzer_on;
    logic [1:0]  lock_mode;
    logic [2:0]  digits_entered;
    logic [3:0]  failed_attempts;
    logic [2:0]  event_code;
  } out_word_t;

  typedef struct packed {
    logic [15:0] secret_code_bcd;
    logic [3:0]  attempt_limit;
    logic [15:0] relock_ticks;
    logic [12:0] locked_duty;
    logic [12:0] unlocked_duty;
  } cfg_t;

endpackage

// File: design/kclc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on kclc_pkg.
module kclc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [kclc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [kclc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kclc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output kclc_pkg::cfg_t                  cfg
);
  import kclc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.secret_code_bcd <= SECRET_CODE_RST;
      cfg_r.attempt_limit   <= ATTEMPT_LIMIT_RST;
      cfg_r.relock_ticks    <= RELOCK_TICKS_RST;
      cfg_r.locked_duty     <= LOCKED_DUTY_RST;
      cfg_r.unlocked_duty   <= UNLOCKED_DUTY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SECRET_CODE:   cfg_r.secret_code_bcd <= cfg_pwdata[15:0];
        REG_ATTEMPT_LIMIT: cfg_r.attempt_limit   <= cfg_pwdata[3:0];
        REG_RELOCK_TICKS:  cfg_r.relock_ticks    <= cfg_pwdata[15:0];
        REG_LOCKED_DUTY:   cfg_r.locked_duty     <= cfg_pwdata[12:0];
        REG_UNLOCKED_DUTY: cfg_r.unlocked_duty   <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SECRET_CODE:   cfg_prdata = {16'd0, cfg_r.secret_code_bcd};
      REG_ATTEMPT_LIMIT: cfg_prdata = {28'd0, cfg_r.attempt_limit};
      REG_RELOCK_TICKS:  cfg_prdata = {16'd0, cfg_r.relock_ticks};
      REG_LOCKED_DUTY:   cfg_prdata = {19'd0, cfg_r.locked_duty};
      REG_UNLOCKED_DUTY: cfg_prdata = {19'd0, cfg_r.unlocked_duty};
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// File: design/kclc_lock_fsm.sv
`timescale 1ns / 1ps
// Lock state machine: mode, entry buffer, attempt counter and relock timer,
// with the result word for the word being applied. Depends on kclc_pkg.
module kclc_lock_fsm #(
  parameter int CODE_DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kclc_pkg::in_word_t  word,
  input  kclc_pkg::cfg_t      cfg,
  output kclc_pkg::out_word_t result
);
  import kclc_pkg::*;

  localparam int CW = $clog2(CODE_DIGITS + 1);

  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    fail_r, fail_nxt;
  logic [15:0]   timer_r, timer_nxt;
  logic [3:0]    entry_r [CODE_DIGITS];
  logic          digit_we;
  logic          is_digit;
  logic          code_ok;
  logic [3:0]    fail_inc;
  logic [2:0]    ev;
  logic [31:0]   code_ext;
  logic [3:0]    count_ext;

  assign is_digit = (word.key_code >= KEY_ZERO) && (word.key_code <= KEY_NINE);
  assign fail_inc = (fail_r == FAIL_MAX) ? FAIL_MAX : fail_r + 4'd1;
  assign code_ext = {16'd0, cfg.secret_code_bcd};

  always_comb begin
    code_ok = (count_r == CW'(CODE_DIGITS));
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_r[i] != code_ext[(CODE_DIGITS - 1 - i) * 4 +: 4]) begin
        code_ok = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    fail_nxt  = fail_r;
    timer_nxt = timer_r;
    ev        = EV_NONE;
    digit_we  = 1'b0;
    if (word.opcode == OP_TICK) begin
      if (mode_r == MODE_OPEN) begin
        if (timer_r <= 16'd1) begin
          timer_nxt = '0;
          count_nxt = '0;
          mode_nxt  = MODE_READY;
          ev        = EV_RELOCKED;
        end else begin
          timer_nxt = timer_r - 16'd1;
        end
      end
    end else begin
      case (mode_r)
        MODE_WRONG: begin
          if (word.key_code == KEY_CLEAR) begin
            count_nxt = '0;
            mode_nxt  = MODE_READY;
          end
        end
        MODE_READY: begin
          if (is_digit) begin
            if (count_r < CW'(CODE_DIGITS)) begin
              digit_we  = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (word.key_code == KEY_CLEAR) begin
            count_nxt = '0;
          end else if (word.key_code == KEY_ENTER) begin
            count_nxt = '0;
            if (code_ok) begin
              fail_nxt  = '0;
              timer_nxt = cfg.relock_ticks;
              mode_nxt  = MODE_OPEN;
              ev        = EV_GRANTED;
            end else begin
              fail_nxt = fail_inc;
              if (fail_inc >= cfg.attempt_limit) begin
                mode_nxt = MODE_ALARM;
                ev       = EV_ALARM;
              end else begin
                mode_nxt = MODE_WRONG;
                ev       = EV_DENIED;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_READY;
      count_r <= '0;
      fail_r  <= '0;
      timer_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      fail_r  <= fail_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (step && digit_we && (count_r == CW'(i))) begin
        entry_r[i] <= word.key_code[3:0];
      end
    end
  end

  assign count_ext = 4'(count_nxt);

  always_comb begin
    result.servo_duty      = (mode_nxt == MODE_OPEN) ? cfg.unlocked_duty : cfg.locked_duty;
    result.led_on          = (mode_nxt == MODE_OPEN);
    result.buzzer_on       = (mode_nxt == MODE_ALARM);
    result.digits_entered  = (count_ext > 4'd7) ? 3'd7 : count_ext[2:0];
    result.failed_attempts = fail_nxt;
    result.event_code      = ev;
    case (mode_nxt)
      MODE_READY: result.lock_mode = LM_READY;
      MODE_OPEN:  result.lock_mode = LM_OPEN;
      MODE_ALARM: result.lock_mode = LM_ALARM;
      MODE_WRONG: result.lock_mode = LM_WRONG;
      default:    result.lock_mode = LM_READY;
    endcase
  end

endmodule

// File: design/keypad_code_lock_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the keypad code lock controller: input register, lock state
// machine, result register and configuration registers. Depends on kclc_pkg.
//
//   channel | ports                         | word
//   input   | in_valid, in_ready, in_word   | opcode, key_code
//   result  | out_valid, out_ready, out_word| servo_duty .. event_code
//   config  | cfg_psel .. cfg_pready        | 5 registers at 4*i
//
// One word per cycle sustained while out_ready keeps the result moving; each
// word passes the input register, then the result register.
// Synchronous active-low reset returns the lock to ready mode and the
// registers to their defaults; the entry buffer is not cleared.
// A stalled result holds the result register and the input register; the
// input side keeps accepting as long as the input register can advance.
module keypad_code_lock_controller_unit #(
  parameter int CODE_DIGITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kclc_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kclc_pkg::out_word_t             out_word,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [kclc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [kclc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kclc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import kclc_pkg::*;

  cfg_t      cfg;
  in_word_t  s1_word_r;
  logic      s1_valid_r;
  out_word_t out_word_r;
  logic      out_valid_r;
  out_word_t result;
  logic      advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  kclc_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  kclc_lock_fsm #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_lock_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .word   (s1_word_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

endmodule
